// File: sv/fts_pkg.sv
// Shared types, codes and tables of the frame transition source mapper.
// Holds the raised-cosine easing table builder and the dot divisibility test.
// No dependencies.
package fts_pkg;

  localparam int MAX_DIM_DEF       = 2048;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [3:0] MODE_CROSSFADE = 4'd1;
  localparam logic [3:0] MODE_PUSH_LR   = 4'd2;
  localparam logic [3:0] MODE_PUSH_RL   = 4'd3;
  localparam logic [3:0] MODE_PUSH_TB   = 4'd4;
  localparam logic [3:0] MODE_PUSH_BT   = 4'd5;
  localparam logic [3:0] MODE_SPLIT     = 4'd7;
  localparam logic [3:0] MODE_CENTRE    = 4'd8;
  localparam logic [3:0] MODE_SQUEEZE   = 4'd9;
  localparam logic [3:0] MODE_WIPE_LR   = 4'd10;
  localparam logic [3:0] MODE_WIPE_RL   = 4'd11;
  localparam logic [3:0] MODE_WIPE_TB   = 4'd12;
  localparam logic [3:0] MODE_WIPE_BT   = 4'd13;
  localparam logic [3:0] MODE_DOTS      = 4'd14;

  localparam logic [1:0] SEL_OUT   = 2'd0;
  localparam logic [1:0] SEL_IN    = 2'd1;
  localparam logic [1:0] SEL_BLEND = 2'd2;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [16:0] EASE_ONE = 17'd65536;

  typedef logic [16:0] ease_tab_t [256];

  typedef struct packed {
    logic [1:0]  sel;
    logic [10:0] sx;
    logic [10:0] sy;
    logic [7:0]  wt;
    logic        sq;
  } map_res_t;

  function automatic logic [16:0] ease_of(int unsigned n);
    logic [63:0]        a;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic [63:0]        e;
    logic signed [63:0] sum;
    if (n == 0) return 17'd0;
    if (n >= 255) return EASE_ONE;
    a = (n >= 128) ? 64'(2 * n - 255) : 64'(255 - 2 * n);
    x = (PI_Q30 * a) / 64'd510;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    if (sum < 0) sum = 64'sd0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    v = (n >= 128) ? ONE_Q30 + 64'(sum) : ONE_Q30 - 64'(sum);
    e = (v + 64'd16384) >> 15;
    if (e > 64'(EASE_ONE)) e = 64'(EASE_ONE);
    return 17'(e);
  endfunction

  function automatic ease_tab_t ease_table();
    ease_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ease_of(i);
    end
    return t;
  endfunction

  // divisibility by 2^sh+1 through the modular inverse mod 4096
  function automatic logic dot_hit(logic [11:0] v, logic [2:0] sh);
    logic [23:0] p;
    logic        hit;
    p = '0;
    case (sh)
      3'd0: hit = ~v[0];
      3'd1: begin
        p = v * 12'd2731;
        hit = (p[11:0] <= 12'd1365);
      end
      3'd2: begin
        p = v * 12'd3277;
        hit = (p[11:0] <= 12'd819);
      end
      3'd3: begin
        p = v * 12'd3641;
        hit = (p[11:0] <= 12'd455);
      end
      3'd4: begin
        p = v * 12'd241;
        hit = (p[11:0] <= 12'd240);
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: sv/fts_map.sv
// Per-mode source mapping of one pixel from eased split positions.
// Also sets up the squeeze divide operands. Depends on fts_pkg.
module fts_map #(
  parameter int DW = 12
) (
  input  logic [3:0]       mode,
  input  logic [DW-1:0]    w,
  input  logic [DW-1:0]    h,
  input  logic [10:0]      x,
  input  logic [10:0]      y,
  input  logic [7:0]       n,
  input  logic [DW-1:0]    iw,
  input  logic [DW-1:0]    ih,
  input  logic [DW-1:0]    half,
  input  logic [2:0]       k5,
  input  logic [4:0]       dot,
  output fts_pkg::map_res_t res,
  output logic [DW-1:0]    k,
  output logic [DW-1:0]    base,
  output logic [DW-1:0]    num,
  output logic [DW-1:0]    d
);

  localparam int CW = ((DW > 11) ? DW : 11) + 2;

  logic [CW-1:0] xe, ye, we, he, iwe, ihe, hfe, w2e, h2e;
  logic          lr_in, rl_in, tb_in, bt_in;
  logic [10:0]   lr_sx, rl_sx, tb_sy, bt_sy;
  logic          dhit;

  assign xe  = CW'(x);
  assign ye  = CW'(y);
  assign we  = CW'(w);
  assign he  = CW'(h);
  assign iwe = CW'(iw);
  assign ihe = CW'(ih);
  assign hfe = CW'(half);
  assign w2e = we >> 1;
  assign h2e = he >> 1;

  assign lr_in = xe < iwe;
  assign lr_sx = lr_in ? 11'(xe + we - iwe) : 11'(xe - iwe);
  assign rl_in = !(xe < we - iwe);
  assign rl_sx = rl_in ? 11'(xe - (we - iwe)) : 11'(xe + iwe);
  assign tb_in = ye < ihe;
  assign tb_sy = tb_in ? 11'(ye + he - ihe) : 11'(ye - ihe);
  assign bt_in = !(ye < he - ihe);
  assign bt_sy = bt_in ? 11'(ye - (he - ihe)) : 11'(ye + ihe);

  assign dhit = (k5 >= 3'd5) ? dot[0] : dot[3'd4 - k5];

  always_comb begin
    res.sel = fts_pkg::SEL_OUT;
    res.sx  = x;
    res.sy  = y;
    res.wt  = '0;
    res.sq  = 1'b0;
    k       = '0;
    base    = '0;
    num     = '0;
    d       = '0;
    if (xe < we && ye < he) begin
      case (mode)
        fts_pkg::MODE_CROSSFADE: begin
          res.sel = fts_pkg::SEL_BLEND;
          res.wt  = n;
        end
        fts_pkg::MODE_PUSH_LR: begin
          res.sel = lr_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
          res.sx  = lr_sx;
        end
        fts_pkg::MODE_PUSH_RL: begin
          res.sel = rl_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
          res.sx  = rl_sx;
        end
        fts_pkg::MODE_PUSH_TB: begin
          res.sel = tb_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
          res.sy  = tb_sy;
        end
        fts_pkg::MODE_PUSH_BT: begin
          res.sel = bt_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
          res.sy  = bt_sy;
        end
        fts_pkg::MODE_SPLIT: begin
          if (ye < h2e) begin
            res.sel = lr_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
            res.sx  = lr_sx;
          end else begin
            res.sel = rl_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
            res.sx  = rl_sx;
          end
        end
        fts_pkg::MODE_CENTRE: begin
          if (xe < hfe) begin
            res.sel = fts_pkg::SEL_IN;
            res.sx  = 11'(we - hfe - w2e + xe);
          end else if (xe >= we - hfe) begin
            res.sel = fts_pkg::SEL_IN;
            res.sx  = 11'(w2e + xe - (we - hfe));
          end
        end
        fts_pkg::MODE_SQUEEZE: begin
          res.sq = 1'b1;
          if (xe < hfe) begin
            res.sel = fts_pkg::SEL_IN;
            k    = DW'(xe);
            num  = DW'(w2e);
            d    = half;
          end else if (xe >= we - hfe) begin
            res.sel = fts_pkg::SEL_IN;
            k    = DW'(xe - (we - hfe));
            base = DW'(w2e);
            num  = DW'(w2e);
            d    = half;
          end else begin
            k    = DW'(xe - hfe);
            num  = w;
            d    = DW'(we - (hfe << 1));
          end
        end
        fts_pkg::MODE_WIPE_LR: res.sel = lr_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_WIPE_RL: res.sel = rl_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_WIPE_TB: res.sel = tb_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_WIPE_BT: res.sel = bt_in ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_DOTS: begin
          if (k5 >= 3'd5) res.sel = dhit ? fts_pkg::SEL_OUT : fts_pkg::SEL_IN;
          else res.sel = dhit ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        end
        default: res.sel = fts_pkg::SEL_OUT;
      endcase
    end
  end

endmodule

// File: sv/frame_transition_source_mapper.sv
// Top level of the frame transition source mapper: config registers and pipeline.
// Depends on fts_pkg and fts_map.
//
//  channel  | handshake          | payload
//  in       | in_valid/in_ready  | pixel_x, pixel_y, progress
//  out      | out_valid/out_ready| source_select, source_x, source_y, blend_weight
//  config   | APB psel/penable   | paddr, pwdata, prdata
//
// One item per cycle when the output is not stalled; the squeeze divider takes
// one quotient bit per stage.
// On a stall the full stages next to the output hold; stages behind an empty one still fill while the output waits.
// rst clears all valid bits and reloads the config registers.
module frame_transition_source_mapper #(
  parameter int MAX_DIM       = fts_pkg::MAX_DIM_DEF,
  parameter int FRACTION_BITS = fts_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] pixel_x,
  input  logic [10:0] pixel_y,
  input  logic [7:0]  progress,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  source_select,
  output logic [10:0] source_x,
  output logic [10:0] source_y,
  output logic [7:0]  blend_weight,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int QW = DW + FRACTION_BITS;
  localparam int NS = QW + 5;
  localparam int SM = QW + 3;

  localparam fts_pkg::ease_tab_t EaseTab = fts_pkg::ease_table();

  typedef struct packed {
    fts_pkg::map_res_t r;
    logic [DW-1:0]     k;
    logic [DW-1:0]     base;
    logic [DW-1:0]     num;
    logic [DW-1:0]     d;
    logic [DW-1:0]     rem;
    logic [QW-1:0]     q;
  } dstage_t;

  // config
  logic [3:0]    mode;
  logic [11:0]   width_raw;
  logic [11:0]   height_raw;
  logic [DW-1:0] w, h;
  logic [1:0]    ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= fts_pkg::MODE_CROSSFADE;
      width_raw  <= 12'd640;
      height_raw <= 12'd480;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        fts_pkg::REG_MODE:   mode       <= pwdata[3:0];
        fts_pkg::REG_WIDTH:  width_raw  <= pwdata[11:0];
        fts_pkg::REG_HEIGHT: height_raw <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      fts_pkg::REG_MODE:   prdata = 32'(mode);
      fts_pkg::REG_WIDTH:  prdata = 32'(width_raw);
      fts_pkg::REG_HEIGHT: prdata = 32'(height_raw);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (width_raw == '0) w = DW'(1);
    else if (32'(width_raw) > MAX_DIM) w = DW'(MAX_DIM);
    else w = DW'(width_raw);
    if (height_raw == '0) h = DW'(1);
    else if (32'(height_raw) > MAX_DIM) h = DW'(MAX_DIM);
    else h = DW'(height_raw);
  end

  // pipeline control
  logic [NS-1:0] v;
  logic [NS-1:0] ld;

  for (genvar i = 0; i < NS; i++) begin : g_ld
    assign ld[i] = out_ready | ~(&v[NS-1:i]);
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage A: easing lookup
  logic [10:0] a_x, a_y;
  logic [7:0]  a_n;
  logic [16:0] a_e;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_x <= pixel_x;
      a_y <= pixel_y;
      a_n <= progress;
      a_e <= EaseTab[progress];
    end
  end

  // stage B: split positions and dot grid hits
  logic [10:0]      b_x, b_y;
  logic [7:0]       b_n;
  logic [DW-1:0]    b_iw, b_ih, b_half;
  logic [2:0]       b_k5;
  logic [4:0]       b_dot;
  logic [DW+16:0]   ew, eh;
  logic [19:0]      e5;
  logic [11:0]      x1, y1;
  logic [4:0]       dot_next;

  assign ew = (DW+17)'(a_e) * (DW+17)'(w);
  assign eh = (DW+17)'(a_e) * (DW+17)'(h);
  assign e5 = 20'(a_e) * 20'd5;
  assign x1 = 12'(a_x) + 12'd1;
  assign y1 = 12'(a_y) + 12'd1;

  for (genvar s = 0; s < 5; s++) begin : g_dot
    assign dot_next[s] = fts_pkg::dot_hit(x1, 3'(s)) & fts_pkg::dot_hit(y1, 3'(s));
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b_x    <= a_x;
      b_y    <= a_y;
      b_n    <= a_n;
      b_iw   <= DW'(ew >> 16);
      b_ih   <= DW'(eh >> 16);
      b_half <= DW'(ew >> 17);
      b_k5   <= 3'(e5 >> 16);
      b_dot  <= dot_next;
    end
  end

  // stage C: mode mapping
  fts_pkg::map_res_t map_r;
  logic [DW-1:0]     map_k, map_base, map_num, map_d;
  dstage_t           c_st;

  fts_map #(.DW(DW)) u_map (
    .mode (mode),
    .w    (w),
    .h    (h),
    .x    (b_x),
    .y    (b_y),
    .n    (b_n),
    .iw   (b_iw),
    .ih   (b_ih),
    .half (b_half),
    .k5   (b_k5),
    .dot  (b_dot),
    .res  (map_r),
    .k    (map_k),
    .base (map_base),
    .num  (map_num),
    .d    (map_d)
  );

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c_st.r    <= map_r;
      c_st.k    <= map_k;
      c_st.base <= map_base;
      c_st.num  <= map_num;
      c_st.d    <= map_d;
      c_st.rem  <= '0;
      c_st.q    <= '0;
    end
  end

  // squeeze step divider, restoring, one quotient bit per stage
  dstage_t dv [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    dstage_t     src;
    dstage_t     nxt;
    logic        bitin;
    logic [DW:0] trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign src = c_st;
    end else begin : g_rest
      assign src = dv[j-1];
    end

    if (j < DW) begin : g_num
      assign bitin = src.num[DW-1-j];
    end else begin : g_zero
      assign bitin = 1'b0;
    end

    assign trial = {src.rem, bitin};
    assign ge    = trial >= {1'b0, src.d};

    always_comb begin
      nxt     = src;
      nxt.rem = ge ? DW'(trial - {1'b0, src.d}) : DW'(trial);
      nxt.q   = {src.q[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (ld[3+j]) dv[j] <= nxt;
    end
  end

  // stage M: scale the step
  fts_pkg::map_res_t m_r;
  logic [DW-1:0]     m_base;
  logic [DW+QW-1:0]  m_prod;

  always_ff @(posedge clk) begin
    if (ld[SM]) begin
      m_r    <= dv[QW-1].r;
      m_base <= dv[QW-1].base;
      m_prod <= (DW+QW)'(dv[QW-1].k) * (DW+QW)'(dv[QW-1].q);
    end
  end

  // stage O: output register
  fts_pkg::map_res_t o_r;
  fts_pkg::map_res_t o_next;

  always_comb begin
    o_next = m_r;
    if (m_r.sq) o_next.sx = 11'(m_base) + 11'(m_prod >> FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) o_r <= o_next;
  end

  assign source_select = o_r.sel;
  assign source_x      = o_r.sx;
  assign source_y      = o_r.sy;
  assign blend_weight  = o_r.wt;

  a_sel_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> source_select != 2'd3)
    else $error("illegal source select");

  a_weight_blend: assert property (@(posedge clk) disable iff (rst)
    out_valid && blend_weight != 8'd0 |-> source_select == fts_pkg::SEL_BLEND)
    else $error("weight outside blend");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready)
    else $error("input stalled with room in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// File: tb/tb.sv
// Testbench for frame_transition_source_mapper: directed and random pixel items per mode.
// Predicts each mapping in-bench and checks results in order; depends on fts_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = 16 + 12 + 5;
  localparam int WATCHDOG_LIMIT = 2000;

  // modes with no transition of their own
  localparam logic [3:0] MODE_NONE  = 4'd0;
  localparam logic [3:0] MODE_SPARE = 4'd6;
  localparam logic [3:0] MODE_TOP   = 4'd15;

  typedef struct packed {
    logic [1:0]  sel;
    logic [10:0] sx;
    logic [10:0] sy;
    logic [7:0]  wt;
  } mapping_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [10:0] pixel_x = '0;
  logic [10:0] pixel_y = '0;
  logic [7:0]  progress = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  source_select;
  logic [10:0] source_x;
  logic [10:0] source_y;
  logic [7:0]  blend_weight;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_transition_source_mapper dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mapping_t    expected_maps[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic [3:0]  cur_mode = fts_pkg::MODE_CROSSFADE;
  logic [11:0] cur_width = 12'd640;
  logic [11:0] cur_height = 12'd480;
  logic [16:0] ease_lut [256];

  function automatic logic [16:0] eased(int unsigned n);
    longint unsigned a, x, x2, term, v, e;
    longint sum;
    if (n == 0) return 17'd0;
    if (n >= 255) return 17'd65536;
    a = (n >= 128) ? 2 * n - 255 : 255 - 2 * n;
    x = (64'd3373259426 * a) / 510;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > 64'd1073741824) sum = 64'd1073741824;
    v = (n >= 128) ? 64'd1073741824 + sum : 64'd1073741824 - sum;
    e = (v + 16384) >> 15;
    if (e > 65536) e = 65536;
    return e[16:0];
  endfunction

  function automatic mapping_t map_pixel(int unsigned x, int unsigned y, int unsigned n);
    int unsigned w, h, iw, ih, half, sel, sx, sy, wt, k5, sh, period, cnt;
    longint unsigned e, step, k, base;
    logic dot;
    mapping_t r;
    w = (cur_width == 0) ? 1 : (cur_width > 2048) ? 2048 : cur_width;
    h = (cur_height == 0) ? 1 : (cur_height > 2048) ? 2048 : cur_height;
    e = 64'(ease_lut[n]);
    iw = 32'((e * w) >> 16);
    ih = 32'((e * h) >> 16);
    half = 32'((e * w) >> 17);
    sel = fts_pkg::SEL_OUT; sx = x; sy = y; wt = 0;
    if (x < w && y < h) begin
      case (cur_mode)
        fts_pkg::MODE_CROSSFADE: begin sel = fts_pkg::SEL_BLEND; wt = n; end
        fts_pkg::MODE_PUSH_LR: if (x < iw) begin sel = fts_pkg::SEL_IN; sx = x + w - iw; end
          else sx = x - iw;
        fts_pkg::MODE_PUSH_RL: if (x < w - iw) sx = x + iw;
          else begin sel = fts_pkg::SEL_IN; sx = x - (w - iw); end
        fts_pkg::MODE_PUSH_TB: if (y < ih) begin sel = fts_pkg::SEL_IN; sy = y + h - ih; end
          else sy = y - ih;
        fts_pkg::MODE_PUSH_BT: if (y < h - ih) sy = y + ih;
          else begin sel = fts_pkg::SEL_IN; sy = y - (h - ih); end
        fts_pkg::MODE_SPLIT: begin
          if (y < h / 2) begin
            if (x < iw) begin sel = fts_pkg::SEL_IN; sx = x + w - iw; end
            else sx = x - iw;
          end else begin
            if (x < w - iw) sx = x + iw;
            else begin sel = fts_pkg::SEL_IN; sx = x - (w - iw); end
          end
        end
        fts_pkg::MODE_CENTRE: begin
          if (x < half) begin sel = fts_pkg::SEL_IN; sx = w - half - w / 2 + x; end
          else if (x >= w - half) begin
            sel = fts_pkg::SEL_IN;
            sx = w / 2 + (x - (w - half));
          end
        end
        fts_pkg::MODE_SQUEEZE: begin
          if (x < half || x >= w - half) begin
            step = (longint'(w / 2) << 16) / half;
            k = (x < half) ? x : x - (w - half);
            base = (x < half) ? 0 : w / 2;
            sel = fts_pkg::SEL_IN;
            sx = 32'(base + ((k * step) >> 16));
          end else begin
            cnt = w - 2 * half;
            step = (longint'(w) << 16) / cnt;
            sx = 32'((longint'(x - half) * step) >> 16);
          end
        end
        fts_pkg::MODE_WIPE_LR: sel = (x < iw) ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_WIPE_RL: sel = (x < w - iw) ? fts_pkg::SEL_OUT : fts_pkg::SEL_IN;
        fts_pkg::MODE_WIPE_TB: sel = (y < ih) ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        fts_pkg::MODE_WIPE_BT: sel = (y < h - ih) ? fts_pkg::SEL_OUT : fts_pkg::SEL_IN;
        fts_pkg::MODE_DOTS: begin
          k5 = 32'((e * 5) >> 16);
          sh = (k5 >= 5) ? 0 : 4 - k5;
          period = (1 << sh) + 1;
          dot = ((y + 1) % period == 0) && ((x + 1) % period == 0);
          if (k5 >= 5) sel = dot ? fts_pkg::SEL_OUT : fts_pkg::SEL_IN;
          else sel = dot ? fts_pkg::SEL_IN : fts_pkg::SEL_OUT;
        end
        default: ;
      endcase
    end
    r.sel = sel[1:0]; r.sx = sx[10:0]; r.sy = sy[10:0]; r.wt = wt[7:0];
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      fts_pkg::REG_MODE:   cur_mode = val[3:0];
      fts_pkg::REG_WIDTH:  cur_width = val[11:0];
      fts_pkg::REG_HEIGHT: cur_height = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic configure(logic [3:0] m, logic [11:0] w, logic [11:0] h);
    drain();
    write_reg(fts_pkg::REG_MODE, 32'(m));
    write_reg(fts_pkg::REG_WIDTH, 32'(w));
    write_reg(fts_pkg::REG_HEIGHT, 32'(h));
  endtask

  task automatic send_item(logic [10:0] x, logic [10:0] y, logic [7:0] n);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; pixel_x <= x; pixel_y <= y; progress <= n;
    expected_maps.push_back(map_pixel(x, y, n));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(int count, int unsigned w, int unsigned h);
    logic [10:0] x, y;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        x = 11'($urandom); y = 11'($urandom);
      end else begin
        x = 11'($urandom_range(0, (w > 2048 ? 2048 : w) - 1));
        y = 11'($urandom_range(0, (h > 2048 ? 2048 : h) - 1));
      end
      send_item(x, y, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    logic [3:0] modes [13] = '{fts_pkg::MODE_CROSSFADE, fts_pkg::MODE_PUSH_LR,
      fts_pkg::MODE_PUSH_RL, fts_pkg::MODE_PUSH_TB, fts_pkg::MODE_PUSH_BT,
      fts_pkg::MODE_SPLIT, fts_pkg::MODE_CENTRE, fts_pkg::MODE_SQUEEZE,
      fts_pkg::MODE_WIPE_LR, fts_pkg::MODE_WIPE_RL, fts_pkg::MODE_WIPE_TB,
      fts_pkg::MODE_WIPE_BT, fts_pkg::MODE_DOTS};
    send_item(11'd0, 11'd0, 8'd0);
    send_item(11'd639, 11'd479, 8'd255);
    send_item(11'd2047, 11'd2047, 8'd128);
    foreach (modes[i]) begin
      configure(modes[i], 12'd640, 12'd480);
      send_item(11'd10, 11'd10, 8'd200);
    end
    configure(fts_pkg::MODE_DOTS, 12'd64, 12'd64);
    send_item(11'd1, 11'd1, 8'd255);
    send_item(11'd2, 11'd1, 8'd255);
    configure(MODE_NONE, 12'd0, 12'd0);
    send_item(11'd0, 11'd0, 8'd100);
    configure(MODE_SPARE, 12'd4095, 12'd4095);
    send_item(11'd2047, 11'd2047, 8'd127);
    configure(MODE_TOP, 12'd2048, 12'd1);
    send_item(11'd5, 11'd0, 8'd64);
  endtask

  task automatic test_random_modes();
    logic [3:0]  m;
    logic [11:0] w, h;
    for (int p = 0; p < 30; p++) begin
      m = (p < 16) ? p[3:0] : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 5))
        0: begin w = 12'd1; h = 12'd1; end
        1: begin w = 12'd2048; h = 12'd2048; end
        2: begin w = 12'($urandom); h = 12'($urandom); end
        default: begin w = 12'($urandom_range(1, 300)); h = 12'($urandom_range(1, 300)); end
      endcase
      configure(m, w, h);
      send_random(30, (w == 0) ? 1 : w, (h == 0) ? 1 : h);
    end
  endtask

  // sender holds off until everything in flight has come back
  task automatic test_hold_off();
    configure(fts_pkg::MODE_SQUEEZE, 12'd100, 12'd50);
    send_random(20, 100, 50);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_maps.size() != 0);
    send_random(20, 100, 50);
  endtask

  always @(posedge clk) begin
    mapping_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item sel=%0d sx=%0d sy=%0d wt=%0d",
            source_select, source_x, source_y, blend_weight);
        end else begin
          want = expected_maps.pop_front();
          if (want.sel !== source_select || want.sx !== source_x ||
              want.sy !== source_y || want.wt !== blend_weight) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp sel=%0d sx=%0d sy=%0d wt=%0d got %0d %0d %0d %0d",
                want.sel, want.sx, want.sy, want.wt,
                source_select, source_x, source_y, blend_weight);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("frame_transition_source_mapper test failed");
        $finish;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    int pause;
    if (rst) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      pause = $urandom_range(0, 6);
      if (pause != 0) begin
        stall_left <= pause - 1;
        out_ready <= 1'b0;
      end
    end else out_ready <= 1'b1;
  end

  initial begin
    for (int i = 0; i < 256; i++) ease_lut[i] = eased(i);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_modes();
    test_hold_off();
    drain();
    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("frame_transition_source_mapper test passed");
    end else begin
      $display("frame_transition_source_mapper test failed");
    end
    $finish;
  end
endmodule

// File: frame_transition_source_mapper.f
sv/fts_pkg.sv
sv/fts_map.sv
sv/frame_transition_source_mapper.sv
tb/tb.sv
